>>> hdl/gad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gad_pkg: shared types and constants for the Gregorian add-days block
// Holds the payload words, the controller/datapath command and status
// groups, the controller states and the month-length helper.
// ----------------------------------------------------------------------------
package gad_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ADD_W   = 15;
    localparam int REM_W   = 16;
    localparam int STEP_W  = 3;

    // Calendar constants
    localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_BEYOND = 4'd13;
    localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'h3FFF;
    localparam logic [YEAR_W-1:0]  CYCLE_LEN    = 14'd400;
    localparam logic [YEAR_W-1:0]  CYCLE_LAST   = 14'd399;
    localparam logic [YEAR_W-1:0]  CENTURY_1    = 14'd100;
    localparam logic [YEAR_W-1:0]  CENTURY_2    = 14'd200;
    localparam logic [YEAR_W-1:0]  CENTURY_3    = 14'd300;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;
    // Highest shift of 400 that still fits the year width (400 << 5 = 12800)
    localparam logic [STEP_W-1:0]  REDUCE_TOP   = 3'd5;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [ADD_W-1:0]   days_to_add;
    } in_word_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SUM,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load;       // capture an accepted input word
        logic reduce;     // one step of year mod 400
        logic sum;        // add one preceding month length
        logic walk_init;  // restart the month counter at January
        logic walk;       // subtract one month and advance
        logic out_load;   // capture the finished date
    } cmd_t;

    typedef struct packed {
        logic reduce_last;
        logic sum_done;
        logic walk_done;
    } status_t;

    // Month length; months outside 1..12 count as zero days
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
            4'd2:                                         len = leap ? FEB_LEAP_LEN : 5'd28;
            default:                                      len = 5'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

>>> hdl/gad_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gad_ctrl: sequencer for the add-days datapath
// Steps an accepted word through year reduction, month summing and the
// month walk, and owns the output valid flag.
// ----------------------------------------------------------------------------
module gad_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire gad_pkg::status_t status,
    output gad_pkg::cmd_t        cmd
);

    gad_pkg::state_t state_reg;
    gad_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // Hold state and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gad_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == gad_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            gad_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = gad_pkg::ST_REDUCE;
                end
            end
            gad_pkg::ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (status.reduce_last)
                begin
                    state_next = gad_pkg::ST_SUM;
                end
            end
            gad_pkg::ST_SUM:
            begin
                if (status.sum_done)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = gad_pkg::ST_WALK;
                end
                else
                begin
                    cmd.sum = 1'b1;
                end
            end
            gad_pkg::ST_WALK:
            begin
                if (!status.walk_done)
                begin
                    cmd.walk = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = gad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gad_pkg::ST_IDLE;
            end
        endcase
    end

    // Set on a finished date, drop when taken
    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule
`default_nettype wire

>>> hdl/gad_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gad_dp: datapath for the add-days block
// Holds the working date, a running year mod 400 for the leap rule, the
// day remainder and the output word.
// ----------------------------------------------------------------------------
module gad_dp (
    input  wire logic              clk,
    input  wire gad_pkg::in_word_t in_data,
    input  wire gad_pkg::cmd_t     cmd,
    output gad_pkg::status_t       status,
    output gad_pkg::out_word_t     out_data
);

    logic [gad_pkg::YEAR_W-1:0]  year_reg;
    logic [gad_pkg::YEAR_W-1:0]  mod400_reg;
    logic [gad_pkg::STEP_W-1:0]  step_reg;
    logic [gad_pkg::MONTH_W-1:0] stop_month_reg;
    logic [gad_pkg::MONTH_W-1:0] month_reg;
    logic [gad_pkg::REM_W-1:0]   rem_reg;
    gad_pkg::out_word_t          out_reg;

    logic [gad_pkg::YEAR_W-1:0]  sub_val;
    logic                        leap;
    logic [gad_pkg::DAY_W-1:0]   cur_len;
    logic [gad_pkg::YEAR_W-1:0]  mod400_inc;

    // Trial subtrahend for the mod 400 reduction
    assign sub_val = gad_pkg::CYCLE_LEN << step_reg;

    // Leap year from year mod 400: multiple of 4 but not a bare century
    assign leap = (mod400_reg[1:0] == 2'b00)
               && (mod400_reg != gad_pkg::CENTURY_1)
               && (mod400_reg != gad_pkg::CENTURY_2)
               && (mod400_reg != gad_pkg::CENTURY_3);

    assign cur_len = gad_pkg::month_len(month_reg, leap);

    // Next year mod 400; the 14-bit year wraps to year zero
    always_comb
    begin
        priority if (year_reg == gad_pkg::YEAR_MAX || mod400_reg == gad_pkg::CYCLE_LAST)
        begin
            mod400_inc = '0;
        end
        else
        begin
            mod400_inc = mod400_reg + 1'b1;
        end
    end

    assign status.reduce_last = (step_reg == '0);
    assign status.sum_done    = (month_reg >= stop_month_reg)
                             || (month_reg == gad_pkg::MONTH_BEYOND);
    assign status.walk_done   = (rem_reg <= {{(gad_pkg::REM_W-gad_pkg::DAY_W){1'b0}}, cur_len});

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            year_reg       <= in_data.start_year;
            mod400_reg     <= in_data.start_year;
            step_reg       <= gad_pkg::REDUCE_TOP;
            stop_month_reg <= in_data.start_month;
            month_reg      <= gad_pkg::MONTH_JAN;
            rem_reg        <= gad_pkg::REM_W'(in_data.start_day)
                            + gad_pkg::REM_W'(in_data.days_to_add);
        end
        else if (cmd.reduce)
        begin
            if (mod400_reg >= sub_val)
            begin
                mod400_reg <= mod400_reg - sub_val;
            end
            step_reg <= step_reg - 1'b1;
        end
        else if (cmd.sum)
        begin
            rem_reg   <= rem_reg + gad_pkg::REM_W'(cur_len);
            month_reg <= month_reg + 1'b1;
        end
        else if (cmd.walk_init)
        begin
            month_reg <= gad_pkg::MONTH_JAN;
        end
        else if (cmd.walk)
        begin
            rem_reg <= rem_reg - gad_pkg::REM_W'(cur_len);
            if (month_reg == gad_pkg::MONTH_DEC)
            begin
                month_reg  <= gad_pkg::MONTH_JAN;
                year_reg   <= year_reg + 1'b1;
                mod400_reg <= mod400_inc;
            end
            else
            begin
                month_reg <= month_reg + 1'b1;
            end
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.end_year  <= year_reg;
            out_reg.end_month <= month_reg;
            out_reg.end_day   <= rem_reg[gad_pkg::DAY_W-1:0];
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

>>> hdl/gregorian_add_days.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_add_days: advance a Gregorian date by a number of days
// Input word: start year, month, day and a day count. Output word: the date
// that lies that many days later.
//
// Usage: both channels are valid/ready; a word moves when valid and ready
// are high at a rising edge. One input word gives exactly one output word.
// The block works on one word at a time. After acceptance it reduces the
// year mod 400 (leap rule), then adds the lengths of the months before the
// start month, then walks months from January of the start year, and then
// loads the result. In the month sum, month zero counts as one and months
// past December as thirteen. The month walk sets the time to a result,
// which grows with the day count.
// in_ready rises again the cycle after the result is loaded.
// The result sits in an output register, so a new word is taken while an
// earlier result waits; if the receiver still stalls when the next result
// is ready, the walk holds until the output register frees.
// Reset (rst_n low, asynchronous) returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module gregorian_add_days (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gad_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gad_pkg::out_word_t     out_data
);

    gad_pkg::cmd_t    cmd;
    gad_pkg::status_t status;

    // Sequencer
    gad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Date arithmetic
    gad_dp u_dp (
        .clk      (clk),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Gregorian add-days block
// Sends start dates with day counts over valid/ready, predicts each end date
// with an independent calendar walk, and checks every output word in order.
// Both sides idle at random; the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned RANDOM_WORDS = 520;
    localparam int unsigned HOLD_AFTER   = 100;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned DRAIN_CYCLES = 1200;

    // Track predicted end dates and compare them with the block's output
    class date_scoreboard;
        gad_pkg::out_word_t due_dates[$];
        int unsigned        mismatches;

        static function bit leap_year(input int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
        endfunction

        // Months outside 1..12 have no days
        static function int unsigned month_days(input int unsigned y,
                                                input int unsigned m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        static function gad_pkg::out_word_t advance_date(input gad_pkg::in_word_t w);
            logic [gad_pkg::YEAR_W-1:0] yr;
            int unsigned                rem;
            int unsigned                mo;
            gad_pkg::out_word_t         res;
            yr  = w.start_year;
            rem = w.start_day + w.days_to_add;
            // Turn the start date into an ordinal within its year
            for (mo = 1; mo < w.start_month; mo++)
                rem += month_days(yr, mo);
            // Walk months from January, wrapping the 14-bit year after December
            mo = 1;
            while (rem > month_days(yr, mo))
            begin
                rem -= month_days(yr, mo);
                mo++;
                if (mo > 12)
                begin
                    mo = 1;
                    yr = yr + 1'b1;
                end
            end
            res.end_year  = yr;
            res.end_month = gad_pkg::MONTH_W'(mo);
            res.end_day   = gad_pkg::DAY_W'(rem);
            return res;
        endfunction

        function void note_start(input gad_pkg::in_word_t w);
            due_dates.push_back(advance_date(w));
        endfunction

        function void check_end(input gad_pkg::out_word_t got);
            gad_pkg::out_word_t want;
            if (due_dates.size() == 0)
            begin
                $display("%0t: unexpected word %0d-%0d-%0d", $time,
                         got.end_year, got.end_month, got.end_day);
                mismatches++;
                return;
            end
            want = due_dates.pop_front();
            if (got.end_year !== want.end_year)
            begin
                $display("%0t: end_year expected %0d got %0d", $time,
                         want.end_year, got.end_year);
                mismatches++;
            end
            if (got.end_month !== want.end_month)
            begin
                $display("%0t: end_month expected %0d got %0d", $time,
                         want.end_month, got.end_month);
                mismatches++;
            end
            if (got.end_day !== want.end_day)
            begin
                $display("%0t: end_day expected %0d got %0d", $time,
                         want.end_day, got.end_day);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    gad_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    gad_pkg::out_word_t out_data;

    date_scoreboard dates = new;
    int unsigned    words_sent = 0;
    logic           sink_hold = 1'b0;
    logic           no_idle = 1'b0;

    gregorian_add_days dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hold reset low at the start, then release it
    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Mostly short idle spans, a few long ones
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic gad_pkg::in_word_t start_word(input int unsigned y,
                                                     input int unsigned m,
                                                     input int unsigned d,
                                                     input int unsigned n);
        gad_pkg::in_word_t w;
        w.start_year  = gad_pkg::YEAR_W'(y);
        w.start_month = gad_pkg::MONTH_W'(m);
        w.start_day   = gad_pkg::DAY_W'(d);
        w.days_to_add = gad_pkg::ADD_W'(n);
        return w;
    endfunction

    // Mostly ordinary dates with short counts; some odd fields and long counts
    function automatic gad_pkg::in_word_t random_word();
        gad_pkg::in_word_t w;
        int unsigned       r;
        r = $urandom_range(0, 99);
        if (r < 75)
            w.start_year = gad_pkg::YEAR_W'($urandom_range(1, 9999));
        else if (r < 92)
            w.start_year = gad_pkg::YEAR_W'($urandom_range(0, gad_pkg::YEAR_MAX));
        else
            w.start_year = gad_pkg::YEAR_W'($urandom_range(gad_pkg::YEAR_MAX - 90,
                                                           gad_pkg::YEAR_MAX));
        w.start_month = ($urandom_range(0, 99) < 85)
                      ? gad_pkg::MONTH_W'($urandom_range(1, 12))
                      : gad_pkg::MONTH_W'($urandom_range(0, 15));
        w.start_day   = ($urandom_range(0, 99) < 85)
                      ? gad_pkg::DAY_W'($urandom_range(1, 31))
                      : gad_pkg::DAY_W'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 50)
            w.days_to_add = gad_pkg::ADD_W'($urandom_range(0, 400));
        else if (r < 85)
            w.days_to_add = gad_pkg::ADD_W'($urandom_range(0, 4000));
        else
            w.days_to_add = gad_pkg::ADD_W'($urandom_range(0, 32767));
        return w;
    endfunction

    // Offer one word, hold it until taken, then idle a while
    task automatic send_word(input gad_pkg::in_word_t w);
        int unsigned gap;
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        dates.note_start(w);
        words_sent++;
        gap = idle_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drive the input side: directed corners, then random words
    initial
    begin : word_source
        int unsigned i;
        in_valid <= 1'b0;
        in_data  <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        send_word(start_word(1, 1, 1, 0));
        send_word(start_word(9999, 12, 31, 32767));
        send_word(start_word(1, 1, 1, 32767));
        // year wrap past the top of the counter, then all fields at all ones
        send_word(start_word(gad_pkg::YEAR_MAX, 12, 31, 1));
        send_word(start_word(gad_pkg::YEAR_MAX, 15, 31, 32767));
        // zero ordinal with month zero and January
        send_word(start_word(2000, 0, 0, 0));
        send_word(start_word(2001, 1, 0, 0));
        send_word(start_word(2001, 0, 5, 10));
        // months beyond December count a full year
        send_word(start_word(2023, 13, 1, 0));
        send_word(start_word(2024, 15, 31, 0));
        // leap rule at 4, 100 and 400
        send_word(start_word(2024, 2, 28, 1));
        send_word(start_word(1900, 2, 28, 1));
        send_word(start_word(2000, 2, 28, 1));
        send_word(start_word(0, 2, 29, 0));
        send_word(start_word(gad_pkg::YEAR_MAX, 2, 29, 0));
        // year rollover and days beyond the month
        send_word(start_word(2023, 12, 31, 1));
        send_word(start_word(2023, 2, 31, 0));
        send_word(start_word(2023, 4, 31, 0));
        send_word(start_word(2019, 1, 1, 365));
        send_word(start_word(8192, 6, 15, 16384));

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            no_idle <= (i >= 300 && i < 360);
            send_word(random_word());
        end
        in_valid <= 1'b0;

        // Drain, then let stray words show up
        while (dates.due_dates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (dates.due_dates.size() != 0)
        begin
            $display("%0t: %0d words never arrived", $time, dates.due_dates.size());
            dates.mismatches++;
        end
        if (dates.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Drive the output side and check each word taken
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                dates.check_end(out_data);
            if (sink_hold)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 30)
            begin
                stall_left = idle_span();
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stall the receiver for a long stretch so the block backs up
    initial
    begin : long_hold
        wait (words_sent >= HOLD_AFTER);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // End a hung run
    initial
    begin : watchdog
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
